>>> rtl/obtvt_pkg.sv
// Package for the order book tick volume tracker.
// Holds beat layouts, function codes and register indexes; no dependencies.
`timescale 1ns / 1ps
package obtvt_pkg;

  // function codes carried in in_tuser
  localparam logic [1:0] FN_LEVEL  = 2'd0;
  localparam logic [1:0] FN_TICK   = 2'd1;
  localparam logic [1:0] FN_COMMIT = 2'd2;
  localparam logic [1:0] FN_QUERY  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_TICK_SIZE = 2'd0;
  localparam logic [1:0] REG_MULT      = 2'd1;
  localparam logic [1:0] REG_HALVE     = 2'd2;
  localparam logic [1:0] REG_SINGLE    = 2'd3;

  // input tdata layout, lowest bit first
  localparam int IN_W       = 288;
  localparam int LVL_LO     = 0;
  localparam int BP_LO      = 3;
  localparam int BV_LO      = 43;
  localparam int AP_LO      = 74;
  localparam int AV_LO      = 114;
  localparam int CV_LO      = 145;
  localparam int CT_LO      = 193;
  localparam int OP_LO      = 255;
  localparam int BUY_BIT    = 286;

  // output tdata width
  localparam int OUT_W      = 224;

  // follow-up action once a division finishes
  localparam logic [1:0] DIV_BID  = 2'd0;
  localparam logic [1:0] DIV_ASK  = 2'd1;
  localparam logic [1:0] DIV_TURN = 2'd2;
  localparam logic [1:0] DIV_AVG  = 2'd3;

endpackage

>>> rtl/order_book_tick_volume_tracker.sv
// Order book tick volume tracker: five-level book, tick statistics, volume query.
// Uses obtvt_pkg for beat layout and codes. One bit-serial divider is shared.
`timescale 1ns / 1ps
// Work per input beat: a level write runs two 64-step divisions, a tick end once
// ready runs one or two divisions, commit and a tick end before ready run none,
// and a query walks the levels one per cycle in five-level mode or takes a single
// weighting step in single-level mode. One item at a time: in_tready returns in
// the same cycle that the result is presented; the shared restoring divider, one
// quotient bit per cycle, sets the rate.
// Reset (rst_n low, synchronous) clears book, totals, flags, counter and held
// values and loads tick_size 1, multiplier 1, both mode bits 0.
module order_book_tick_volume_tracker
  import obtvt_pkg::*;
#(
  parameter int LEVELS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // level, bid_price, bid_volume, ask_price, ask_volume, cum_volume,
  // turnover_total, order_price, buy_side, one pad bit
  input  logic [IN_W-1:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ready_res, tick_index, trade_volume, turnover_ticks, average_price,
  // order_volume
  output logic [OUT_W-1:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_AVGP = 3'd4;
  localparam logic [2:0] S_QRY  = 3'd5;
  localparam logic [2:0] S_QSL  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // configuration
  logic [31:0] tick_size_r;
  logic [15:0] mult_r;
  logic        halve_r, single_r;

  // book
  logic [30:0] bid_ticks_r [LEVELS];
  logic [30:0] bid_sizes_r [LEVELS];
  logic [30:0] ask_ticks_r [LEVELS];
  logic [30:0] ask_sizes_r [LEVELS];
  logic [30:0] bid_ticks_nxt [LEVELS];
  logic [30:0] bid_sizes_nxt [LEVELS];
  logic [30:0] ask_ticks_nxt [LEVELS];
  logic [30:0] ask_sizes_nxt [LEVELS];

  logic        bbp_r, bbp_nxt;
  logic [47:0] prev_cv_r, prev_cv_nxt;
  logic [61:0] prev_ct_r, prev_ct_nxt;
  logic        ready_r, ready_nxt;
  logic [30:0] cnt_r, cnt_nxt;
  logic [31:0] held_tv_r, held_tv_nxt;
  logic [47:0] held_turn_r, held_turn_nxt;
  logic [47:0] held_avg_r, held_avg_nxt;

  // sequencer and item
  logic [2:0]  state_r, state_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [IN_W-1:0] item_r, item_nxt;
  logic [LVL_W-1:0] idx_r, idx_nxt;
  logic [63:0] ov_r, ov_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] tv_r, tv_nxt;
  logic [30:0] bt_r, bt_nxt;

  // shared divider
  logic [63:0] dnum_r, dnum_nxt;
  logic [47:0] dden_r, dden_nxt;
  logic [47:0] drem_r, drem_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic [1:0]  dret_r, dret_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // item fields
  logic [2:0]  it_level;
  logic [39:0] it_bp, it_ap;
  logic [30:0] it_bv, it_av, it_op;
  logic [47:0] it_cv;
  logic [61:0] it_ct;
  logic        it_buy;

  assign it_level = item_r[LVL_LO +: 3];
  assign it_bp    = item_r[BP_LO +: 40];
  assign it_bv    = item_r[BV_LO +: 31];
  assign it_ap    = item_r[AP_LO +: 40];
  assign it_av    = item_r[AV_LO +: 31];
  assign it_cv    = item_r[CV_LO +: 48];
  assign it_ct    = item_r[CT_LO +: 62];
  assign it_op    = item_r[OP_LO +: 31];
  assign it_buy   = item_r[BUY_BIT];

  logic [31:0] eff_tick;
  logic [15:0] eff_mult;
  assign eff_tick = (tick_size_r == 32'd0) ? 32'd1 : tick_size_r;
  assign eff_mult = (mult_r == 16'd0) ? 16'd1 : mult_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // working values
  logic [48:0] rem_s;
  logic        dge;
  logic        rnd;
  logic [63:0] qr;
  logic signed [48:0] dv_s;
  logic signed [62:0] dt_s;
  logic [61:0] mag;
  logic [47:0] dprod;
  logic        rdy_c;
  logic [47:0] turn_c;
  logic signed [47:0] turn_h;
  logic signed [31:0] tv_h;
  logic [47:0] abs_turn;
  logic [32:0] mid_sum;
  logic [30:0] qb, qa, qbs, qas;
  logic [31:0] diff_c;
  logic [30:0] size_c;
  logic [62:0] prod_c;
  logic        hit_c, neg_c;

  always_comb begin
    rem_s = {drem_r, dnum_r[63]};
    dge   = rem_s >= {1'b0, dden_r};
    rnd   = {drem_r, 1'b0} >= {1'b0, dden_r};
    qr    = dnum_r + {63'd0, rnd};
    dv_s  = $signed({1'b0, it_cv}) - $signed({1'b0, prev_cv_r});
    dt_s  = $signed({1'b0, it_ct}) - $signed({1'b0, prev_ct_r});
    mag   = dt_s[62] ? 62'(-dt_s) : dt_s[61:0];
    dprod = 48'(eff_tick) * 48'(eff_mult);
    rdy_c = ready_r | (bbp_r && (it_cv != 48'd0) && (prev_ct_r != 62'd0));
    // magnitude and sign to 48-bit signed with saturation
    if (neg_r) begin
      turn_c = (qr > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : 48'(-qr[47:0]);
    end else begin
      turn_c = (qr > 64'h0000_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : qr[47:0];
    end
    // halve toward zero
    turn_h = halve_r ? ($signed(turn_c) + $signed({47'd0, turn_c[47]})) >>> 1
                     : $signed(turn_c);
    tv_h   = halve_r ? ($signed(tv_r) + $signed({31'd0, tv_r[31]})) >>> 1
                     : $signed(tv_r);
    abs_turn = held_turn_r[47] ? 48'(-held_turn_r) : held_turn_r;
    mid_sum  = {2'b0, ask_ticks_r[0]} + {2'b0, bid_ticks_r[0]};
    qb  = bid_ticks_r[idx_r];
    qa  = ask_ticks_r[idx_r];
    qbs = bid_sizes_r[idx_r];
    qas = ask_sizes_r[idx_r];
    // single-level weighting
    hit_c  = 1'b1;
    neg_c  = 1'b0;
    diff_c = 32'd0;
    size_c = 31'd0;
    if (it_buy) begin
      if (it_op <= bid_ticks_r[0]) begin
        diff_c = {1'b0, bid_ticks_r[0]} - {1'b0, it_op} + 32'd1;
        size_c = bid_sizes_r[0];
      end else if (it_op >= ask_ticks_r[0]) begin
        diff_c = {1'b0, it_op} - {1'b0, ask_ticks_r[0]} + 32'd1;
        size_c = ask_sizes_r[0];
        neg_c  = 1'b1;
      end else begin
        hit_c = 1'b0;
      end
    end else begin
      if (it_op >= ask_ticks_r[0]) begin
        diff_c = {1'b0, it_op} - {1'b0, ask_ticks_r[0]} + 32'd1;
        size_c = ask_sizes_r[0];
      end else if (it_op <= bid_ticks_r[0]) begin
        diff_c = {1'b0, bid_ticks_r[0]} - {1'b0, it_op} + 32'd1;
        size_c = bid_sizes_r[0];
        neg_c  = 1'b1;
      end else begin
        hit_c = 1'b0;
      end
    end
    prod_c = 63'(diff_c) * 63'(size_c);
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    ov_nxt        = ov_r;
    neg_nxt       = neg_r;
    tv_nxt        = tv_r;
    bt_nxt        = bt_r;
    dnum_nxt      = dnum_r;
    dden_nxt      = dden_r;
    drem_nxt      = drem_r;
    dcnt_nxt      = dcnt_r;
    dret_nxt      = dret_r;
    bid_ticks_nxt = bid_ticks_r;
    bid_sizes_nxt = bid_sizes_r;
    ask_ticks_nxt = ask_ticks_r;
    ask_sizes_nxt = ask_sizes_r;
    bbp_nxt       = bbp_r;
    prev_cv_nxt   = prev_cv_r;
    prev_ct_nxt   = prev_ct_r;
    ready_nxt     = ready_r;
    cnt_nxt       = cnt_r;
    held_tv_nxt   = held_tv_r;
    held_turn_nxt = held_turn_r;
    held_avg_nxt  = held_avg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drop the output beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          item_nxt  = in_tdata;
          func_nxt  = in_tuser;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        ov_nxt    = 64'd0;
        idx_nxt   = '0;
        state_nxt = S_DONE;
        dcnt_nxt  = 7'd64;
        drem_nxt  = 48'd0;
        case (func_r)
          FN_LEVEL: begin
            if (it_level < 3'(LEVELS)) begin
              // bid price to ticks first
              dnum_nxt  = {24'd0, it_bp};
              dden_nxt  = {16'd0, eff_tick};
              dret_nxt  = DIV_BID;
              state_nxt = S_DIV;
            end
          end
          FN_TICK: begin
            ready_nxt = rdy_c;
            if (rdy_c) begin
              if (cnt_r != 31'h7FFF_FFFF) begin
                cnt_nxt = cnt_r + 31'd1;
              end
              if (dv_s > 49'sd2147483647) begin
                tv_nxt = 32'h7FFF_FFFF;
              end else if (dv_s < -49'sd2147483648) begin
                tv_nxt = 32'h8000_0000;
              end else begin
                tv_nxt = dv_s[31:0];
              end
              neg_nxt   = dt_s[62];
              dnum_nxt  = {2'd0, mag};
              dden_nxt  = dprod;
              dret_nxt  = DIV_TURN;
              state_nxt = S_DIV;
            end
          end
          FN_COMMIT: begin
            prev_cv_nxt = it_cv;
            prev_ct_nxt = it_ct;
          end
          FN_QUERY: begin
            state_nxt = single_r ? S_QSL : S_QRY;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DIV: begin
        // one restoring step: quotient bit shifts in at the bottom
        drem_nxt = dge ? 48'(rem_s - {1'b0, dden_r}) : rem_s[47:0];
        dnum_nxt = {dnum_r[62:0], dge};
        dcnt_nxt = dcnt_r - 7'd1;
        if (dcnt_r == 7'd1) begin
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        state_nxt = S_DONE;
        case (dret_r)
          DIV_BID: begin
            bt_nxt    = (qr > 64'd2147483647) ? 31'h7FFF_FFFF : qr[30:0];
            dnum_nxt  = {24'd0, it_ap};
            dden_nxt  = {16'd0, eff_tick};
            drem_nxt  = 48'd0;
            dcnt_nxt  = 7'd64;
            dret_nxt  = DIV_ASK;
            state_nxt = S_DIV;
          end
          DIV_ASK: begin
            bid_ticks_nxt[it_level[LVL_W-1:0]] = bt_r;
            bid_sizes_nxt[it_level[LVL_W-1:0]] = it_bv;
            ask_ticks_nxt[it_level[LVL_W-1:0]] =
              (qr > 64'd2147483647) ? 31'h7FFF_FFFF : qr[30:0];
            ask_sizes_nxt[it_level[LVL_W-1:0]] = it_av;
            if (it_level == 3'd0) begin
              bbp_nxt = (it_bp != 40'd0);
            end
          end
          DIV_TURN: begin
            held_turn_nxt = turn_h;
            held_tv_nxt   = tv_h;
            state_nxt     = S_AVGP;
          end
          DIV_AVG: begin
            held_avg_nxt = turn_c;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_AVGP: begin
        state_nxt = S_DONE;
        if (!held_tv_r[31] && (held_tv_r != 32'd0)) begin
          // Q16 average: |turnover| << 16 over volume, sign from turnover
          neg_nxt   = held_turn_r[47];
          dnum_nxt  = {abs_turn, 16'd0};
          dden_nxt  = {16'd0, held_tv_r};
          drem_nxt  = 48'd0;
          dcnt_nxt  = 7'd64;
          dret_nxt  = DIV_AVG;
          state_nxt = S_DIV;
        end else begin
          // midpoint in Q16; the sum stays below 2^32 so no saturation
          held_avg_nxt = {mid_sum[32:0], 15'd0};
        end
      end

      S_QRY: begin
        // walk one level per cycle, stop at the first level that does not cross
        state_nxt = S_DONE;
        if (it_buy ? (it_op <= qb) : (it_op >= qa)) begin
          ov_nxt = ov_r + {33'd0, it_buy ? qbs : qas};
          if (idx_r != LVL_W'(LEVELS - 1)) begin
            idx_nxt   = idx_r + LVL_W'(1);
            state_nxt = S_QRY;
          end
        end else if (it_buy ? (it_op >= qa) : (it_op <= qb)) begin
          ov_nxt = ov_r - {33'd0, it_buy ? qas : qbs};
          if (idx_r != LVL_W'(LEVELS - 1)) begin
            idx_nxt   = idx_r + LVL_W'(1);
            state_nxt = S_QRY;
          end
        end
      end

      S_QSL: begin
        if (hit_c) begin
          ov_nxt = neg_c ? 64'(-{1'b0, prod_c}) : {1'b0, prod_c};
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(func_r == FN_QUERY) ? ov_r : 64'd0,
                           held_avg_r, held_turn_r, held_tv_r, cnt_r, ready_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_size_r <= 32'd1;
      mult_r      <= 16'd1;
      halve_r     <= 1'b0;
      single_r    <= 1'b0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bbp_r       <= 1'b0;
      prev_cv_r   <= 48'd0;
      prev_ct_r   <= 62'd0;
      ready_r     <= 1'b0;
      cnt_r       <= 31'd0;
      held_tv_r   <= 32'd0;
      held_turn_r <= 48'd0;
      held_avg_r  <= 48'd0;
      for (int i = 0; i < LEVELS; i++) begin
        bid_ticks_r[i] <= 31'd0;
        bid_sizes_r[i] <= 31'd0;
        ask_ticks_r[i] <= 31'd0;
        ask_sizes_r[i] <= 31'd0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TICK_SIZE: tick_size_r <= cfg_wdata;
          REG_MULT:      mult_r      <= cfg_wdata[15:0];
          REG_HALVE:     halve_r     <= cfg_wdata[0];
          REG_SINGLE:    single_r    <= cfg_wdata[0];
          default:       ;
        endcase
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bbp_r       <= bbp_nxt;
      prev_cv_r   <= prev_cv_nxt;
      prev_ct_r   <= prev_ct_nxt;
      ready_r     <= ready_nxt;
      cnt_r       <= cnt_nxt;
      held_tv_r   <= held_tv_nxt;
      held_turn_r <= held_turn_nxt;
      held_avg_r  <= held_avg_nxt;
      bid_ticks_r <= bid_ticks_nxt;
      bid_sizes_r <= bid_sizes_nxt;
      ask_ticks_r <= ask_ticks_nxt;
      ask_sizes_r <= ask_sizes_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    ov_r       <= ov_nxt;
    neg_r      <= neg_nxt;
    tv_r       <= tv_nxt;
    bt_r       <= bt_nxt;
    dnum_r     <= dnum_nxt;
    dden_r     <= dden_nxt;
    drem_r     <= drem_nxt;
    dcnt_r     <= dcnt_nxt;
    dret_r     <= dret_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> verif/tb_order_book_tick_volume_tracker.sv
// Testbench for the order book tick volume tracker.
// Drives stream beats and register writes, predicts every result beat in place.
// Depends on obtvt_pkg and the order_book_tick_volume_tracker RTL.
`timescale 1ns / 1ps
module tb_order_book_tick_volume_tracker;
  import obtvt_pkg::*;

  localparam int NLVL = 5;
  localparam logic [63:0] TMAX = 64'h7FFF_FFFF;
  localparam longint S48MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint S48MIN = -64'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  level;
    logic [39:0] bp;
    logic [30:0] bv;
    logic [39:0] ap;
    logic [30:0] av;
    logic [47:0] cv;
    logic [61:0] ct;
    logic [30:0] op;
    logic        buy;
  } book_item_t;

  // highest field first, so ready lands in bit 0
  typedef struct packed {
    logic [63:0] ord_vol;
    logic [47:0] avg;
    logic [47:0] turn;
    logic [31:0] trade_vol;
    logic [30:0] tick_idx;
    logic        ready;
  } book_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  order_book_tick_volume_tracker u_top (.*);

  // predictor copy of the block's state and registers
  logic [31:0] m_tick, m_mult;
  logic m_halve, m_single;
  logic [31:0] m_bt[NLVL], m_bs[NLVL], m_at[NLVL], m_as[NLVL];
  logic m_bbpos, m_ready;
  logic [47:0] m_pcv;
  logic [61:0] m_pct;
  logic [30:0] m_cnt;
  longint m_tv, m_turn, m_avg;

  book_result_t expected_q[$];
  int errors = 0;
  bit hold_off = 0;

  function automatic logic [31:0] to_ticks(logic [39:0] raw);
    logic [63:0] t, q;
    t = (m_tick == 0) ? 64'd1 : 64'(m_tick);
    q = (2 * 64'(raw) + t) / (2 * t);
    return (q > TMAX) ? TMAX[31:0] : q[31:0];
  endfunction

  function automatic longint sat48(logic [63:0] mag, bit neg);
    if (neg) return (mag > 64'h8000_0000_0000) ? S48MIN : -longint'(mag);
    return (mag > 64'(S48MAX)) ? S48MAX : longint'(mag);
  endfunction

  task automatic close_tick(logic [47:0] cv, logic [61:0] ct);
    longint dv, dt, tv, tn;
    logic [63:0] mag, d, q, m, num, a, r, s;
    if (!m_ready && m_bbpos && cv > 0 && m_pct > 0) m_ready = 1;
    if (!m_ready) return;
    if (64'(m_cnt) < TMAX) m_cnt++;
    dv = longint'(64'(cv)) - longint'(64'(m_pcv));
    if (dv > 64'sd2147483647) dv = 64'sd2147483647;
    if (dv < -64'sd2147483648) dv = -64'sd2147483648;
    tv = dv;
    dt = longint'(64'(ct)) - longint'(64'(m_pct));
    mag = (dt < 0) ? 64'(-dt) : 64'(dt);
    d = ((m_tick == 0) ? 64'd1 : 64'(m_tick)) * ((m_mult[15:0] == 0) ? 64'd1 : 64'(m_mult[15:0]));
    q = (2 * mag + d) / (2 * d);
    tn = sat48(q, dt < 0);
    if (m_halve) begin
      tv = tv / 2;
      tn = tn / 2;
    end
    if (tv > 0) begin
      m = (tn < 0) ? 64'(-tn) : 64'(tn);
      num = m << 16;
      a = num / 64'(tv);
      r = num % 64'(tv);
      if (2 * r >= 64'(tv)) a++;
      m_avg = sat48(a, tn < 0);
    end else begin
      s = (64'(m_at[0]) + 64'(m_bt[0])) << 15;
      m_avg = (s > 64'(S48MAX)) ? S48MAX : longint'(s);
    end
    m_tv = tv;
    m_turn = tn;
  endtask

  function automatic longint volume_at_price(longint op, bit buy);
    longint ov, b0, a0, bp, ap;
    ov = 0;
    b0 = longint'(64'(m_bt[0]));
    a0 = longint'(64'(m_at[0]));
    if (!m_single) begin
      for (int i = 0; i < NLVL; i++) begin
        bp = longint'(64'(m_bt[i]));
        ap = longint'(64'(m_at[i]));
        if (buy) begin
          if (op <= bp) ov += longint'(64'(m_bs[i]));
          else if (op >= ap) ov -= longint'(64'(m_as[i]));
          else break;
        end else begin
          if (op >= ap) ov += longint'(64'(m_as[i]));
          else if (op <= bp) ov -= longint'(64'(m_bs[i]));
          else break;
        end
      end
    end else if (buy) begin
      if (op <= b0) ov = (b0 - op + 1) * longint'(64'(m_bs[0]));
      else if (op >= a0) ov = -(longint'(64'(m_as[0])) * (op - a0 + 1));
    end else begin
      if (op >= a0) ov = (op - a0 + 1) * longint'(64'(m_as[0]));
      else if (op <= b0) ov = -(longint'(64'(m_bs[0])) * (b0 - op + 1));
    end
    return ov;
  endfunction

  // advance the predictor by one accepted beat and queue its result
  task automatic predict_beat(book_item_t it);
    book_result_t res;
    longint ov;
    ov = 0;
    case (it.func)
      FN_LEVEL: if (it.level < NLVL) begin
        m_bt[it.level] = to_ticks(it.bp);
        m_bs[it.level] = 32'(it.bv);
        m_at[it.level] = to_ticks(it.ap);
        m_as[it.level] = 32'(it.av);
        if (it.level == 0) m_bbpos = (it.bp > 0);
      end
      FN_TICK: close_tick(it.cv, it.ct);
      FN_COMMIT: begin
        m_pcv = it.cv;
        m_pct = it.ct;
      end
      default: ov = volume_at_price(longint'(64'(it.op)), it.buy);
    endcase
    res.ready = m_ready;
    res.tick_idx = m_cnt;
    res.trade_vol = m_tv[31:0];
    res.turn = m_turn[47:0];
    res.avg = m_avg[47:0];
    res.ord_vol = ov;
    expected_q.push_back(res);
  endtask

  // send one beat; the sender drops into random gaps between bursts
  // valid stays up after a beat until a gap before a later burst or a drain takes it down
  int burst_left = 0;
  task automatic send_beat(book_item_t it);
    logic [IN_W-1:0] beat;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    beat = '0;
    beat[LVL_LO +: 3] = it.level;
    beat[BP_LO +: 40] = it.bp;
    beat[BV_LO +: 31] = it.bv;
    beat[AP_LO +: 40] = it.ap;
    beat[AV_LO +: 31] = it.av;
    beat[CV_LO +: 48] = it.cv;
    beat[CT_LO +: 62] = it.ct;
    beat[OP_LO +: 31] = it.op;
    beat[BUY_BIT] = it.buy;
    in_tdata <= beat;
    in_tuser <= it.func;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(it);
    @(negedge clk);
  endtask

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off) out_tready <= 0;
      else case ($urandom_range(0, 3))
        0: out_tready <= ($urandom_range(0, 1) == 1);
        1: out_tready <= ($urandom_range(0, 7) != 0);
        default: out_tready <= 1;
      endcase
      @(negedge clk);
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    book_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with none expected: %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.ready !== want.ready) begin
          $display("%0t: ready exp %0d got %0d", $time, want.ready, got.ready); errors++;
        end
        if (got.tick_idx !== want.tick_idx) begin
          $display("%0t: tick_index exp %0d got %0d", $time, want.tick_idx, got.tick_idx);
          errors++;
        end
        if (got.trade_vol !== want.trade_vol) begin
          $display("%0t: trade_volume exp %h got %h", $time, want.trade_vol, got.trade_vol);
          errors++;
        end
        if (got.turn !== want.turn) begin
          $display("%0t: turnover exp %h got %h", $time, want.turn, got.turn); errors++;
        end
        if (got.avg !== want.avg) begin
          $display("%0t: average exp %h got %h", $time, want.avg, got.avg); errors++;
        end
        if (got.ord_vol !== want.ord_vol) begin
          $display("%0t: order_volume exp %h got %h", $time, want.ord_vol, got.ord_vol);
          errors++;
        end
      end
    end
  end

  // register writes happen only with the block idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_TICK_SIZE: m_tick = val;
      REG_MULT: m_mult = {16'd0, val[15:0]};
      REG_HALVE: m_halve = val[0];
      default: m_single = val[0];
    endcase
  endtask

  // drop valid, wait out every result, end on a falling edge
  task automatic drain();
    in_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic book_item_t blank_item(logic [1:0] f);
    book_item_t it;
    it = '0;
    it.func = f;
    return it;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic book_item_t level_item(logic [2:0] lv, logic [39:0] bp, logic [39:0] ap);
    book_item_t it;
    it = blank_item(FN_LEVEL);
    it.level = lv;
    it.bp = bp;
    it.ap = ap;
    it.bv = 31'($urandom_range(0, 1000));
    it.av = 31'($urandom_range(0, 1000));
    return it;
  endfunction

  // extremes of the fields and each named special case
  task automatic test_directed();
    book_item_t it;
    send_beat(blank_item(FN_TICK));
    it = level_item(3'd0, '1, '1);
    it.bv = '1; it.av = '1;
    send_beat(it);
    it = level_item(3'd5, 40'd100, 40'd200);
    send_beat(it);
    it = level_item(3'd7, '1, '1);
    send_beat(it);
    it = blank_item(FN_QUERY); it.op = '1; it.buy = 1;
    send_beat(it);
    drain();
    write_reg(REG_TICK_SIZE, 32'd10);
    write_reg(REG_MULT, 32'd10);
    for (int l = 0; l < NLVL; l++)
      send_beat(level_item(3'(l), 40'd1005 - 40'(l * 10), 40'd1010 + 40'(l * 10)));
    it = blank_item(FN_COMMIT); it.cv = 48'd100; it.ct = 62'd50000;
    send_beat(it);
    it = blank_item(FN_TICK); it.cv = 48'd200; it.ct = 62'd150000;
    send_beat(it);
    it = blank_item(FN_TICK); it.cv = '1; it.ct = '1;
    send_beat(it);
    it = blank_item(FN_TICK); it.cv = 48'd0; it.ct = 62'd0;
    send_beat(it);
    it = blank_item(FN_QUERY); it.op = 31'd99; it.buy = 1;
    send_beat(it);
    it = blank_item(FN_QUERY); it.op = 31'd103; it.buy = 0;
    send_beat(it);
    it = blank_item(FN_QUERY); it.op = 31'd0; it.buy = 0;
    send_beat(it);
    drain();
    write_reg(REG_TICK_SIZE, 32'd0);
    write_reg(REG_MULT, 32'd0);
    write_reg(REG_HALVE, 32'd1);
    write_reg(REG_SINGLE, 32'd1);
    it = blank_item(FN_TICK); it.cv = 48'd7; it.ct = 62'd1;
    send_beat(it);
    it = blank_item(FN_QUERY); it.op = 31'd0; it.buy = 1;
    send_beat(it);
    it = blank_item(FN_QUERY); it.op = '1; it.buy = 0;
    send_beat(it);
    drain();
  endtask

  // well-formed market sessions with random content, some noise mixed in
  task automatic test_random(int n);
    book_item_t it;
    logic [47:0] cv;
    logic [61:0] ct;
    logic [39:0] mid;
    int scale;
    cv = 48'($urandom_range(1, 1000));
    ct = 62'($urandom_range(1, 100000));
    for (int k = 0; k < n; k++) begin
      scale = $urandom_range(0, 9);
      mid = (scale == 0) ? 40'(rnd64()) : 40'($urandom_range(1000, 100000));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          it = level_item(3'($urandom_range(0, 4)), mid - 40'($urandom_range(0, 500)),
                          mid + 40'($urandom_range(0, 500)));
          if (scale == 1) begin it.bv = 31'($urandom()); it.av = 31'($urandom()); end
        end
        3, 4: begin
          it = blank_item(FN_TICK);
          cv += 48'($urandom_range(0, 500));
          ct += 62'($urandom_range(0, 5000000));
          if (scale == 2) begin cv = 48'(rnd64()); ct = 62'(rnd64()); end
          it.cv = cv; it.ct = ct;
        end
        5: begin
          it = blank_item(FN_COMMIT);
          it.cv = cv; it.ct = ct;
          if (scale == 3) begin it.cv = 48'(rnd64()); it.ct = 62'(rnd64()); end
        end
        6, 7: begin
          it = blank_item(FN_QUERY);
          it.op = (scale == 4) ? 31'($urandom()) : 31'($urandom_range(0, 12000));
          it.buy = 1'($urandom_range(0, 1));
        end
        default: begin
          it.func = 2'($urandom()); it.level = 3'($urandom());
          it.bp = 40'(rnd64()); it.ap = 40'(rnd64());
          it.bv = 31'($urandom()); it.av = 31'($urandom());
          it.cv = 48'(rnd64()); it.ct = 62'(rnd64());
          it.op = 31'($urandom()); it.buy = 1'($urandom());
        end
      endcase
      send_beat(it);
    end
    drain();
  endtask

  // hold the receiver off so the block fills up and stalls its input
  task automatic test_backpressure();
    book_item_t it;
    hold_off = 1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 12; k++) begin
        it = blank_item(FN_QUERY); it.op = 31'($urandom()); it.buy = k[0];
        send_beat(it);
      end
    join
    drain();
  endtask

  initial begin
    m_tick = 1; m_mult = 1; m_halve = 0; m_single = 0;
    for (int i = 0; i < NLVL; i++) begin
      m_bt[i] = 0; m_bs[i] = 0; m_at[i] = 0; m_as[i] = 0;
    end
    m_bbpos = 0; m_ready = 0; m_pcv = 0; m_pct = 0; m_cnt = 0;
    m_tv = 0; m_turn = 0; m_avg = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_directed();
    write_reg(REG_TICK_SIZE, 32'd1);
    write_reg(REG_MULT, 32'd1);
    write_reg(REG_HALVE, 32'd0);
    write_reg(REG_SINGLE, 32'd0);
    test_random(200);
    write_reg(REG_TICK_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_MULT, 32'd65535);
    test_random(100);
    write_reg(REG_TICK_SIZE, 32'd25);
    write_reg(REG_MULT, 32'd3);
    write_reg(REG_HALVE, 32'd1);
    write_reg(REG_SINGLE, 32'd1);
    test_random(200);
    test_backpressure();
    write_reg(REG_HALVE, 32'd0);
    write_reg(REG_SINGLE, 32'd0);
    test_random(130);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/obtvt_pkg.sv
rtl/order_book_tick_volume_tracker.sv
verif/tb_order_book_tick_volume_tracker.sv
